### rtl/core/sdf_pkg.sv
// Shared types, widths and register codes for the spring-damper force core.
package sdf_pkg;

  localparam int FRAC_BITS = 16;

  localparam int IN_W   = 32;
  localparam int DW     = IN_W + 1;
  localparam int SQ_W   = 2 * (DW - 1);
  localparam int SUM_W  = SQ_W + 2;
  localparam int ROOT_W = SUM_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int DVP_W  = DW + IN_W;
  localparam int DVC_W  = DVP_W - FRAC_BITS;
  localparam int QW     = FRAC_BITS + 1;
  localparam int U_W    = FRAC_BITS + 2;
  localparam int NUM_W  = DW + FRAC_BITS;
  localparam int DIFF_W = ROOT_W + 2;
  localparam int SPP_W  = DIFF_W + IN_W;
  localparam int SPR_W  = SPP_W - FRAC_BITS;
  localparam int TP_W   = DVC_W + U_W;
  localparam int TERM_W = DVC_W;
  localparam int DAMP_W = TERM_W + 2;
  localparam int TOT_W  = DAMP_W + 1;
  localparam int FP_W   = TOT_W + U_W;
  localparam int FR_W   = FP_W - FRAC_BITS;

  typedef enum logic [1:0] {
    REG_REST   = 2'd0,
    REG_STIFF  = 2'd1,
    REG_DAMP   = 2'd2,
    REG_PLANAR = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [30:0]        rest_length;
    logic [30:0]        stiffness;
    logic signed [31:0] damping_coeff;
    logic               planar_mode;
  } cfg_t;

  typedef struct packed {
    logic zero;
    logic planar;
    logic vsmall;
    logic lsmall;
  } flags_t;

  typedef struct packed {
    logic [2:0][DW-1:0]    d;
    logic [2:0][DVC_W-1:0] dvc;
    flags_t                fl;
  } sq_side_t;

  typedef struct packed {
    logic [2:0][DVC_W-1:0] dvc;
    logic [SPP_W-1:0]      spring_prod;
    flags_t                fl;
  } dv_side_t;

endpackage

### rtl/core/sdf_regs.sv
// Configuration register file behind the APB-style port.
module sdf_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output sdf_pkg::cfg_t cfg
);

  sdf_pkg::reg_idx_t idx;

  assign idx = sdf_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rest_length   <= '0;
      cfg.stiffness     <= '0;
      cfg.damping_coeff <= '0;
      cfg.planar_mode   <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        sdf_pkg::REG_REST:   cfg.rest_length   <= pwdata[30:0];
        sdf_pkg::REG_STIFF:  cfg.stiffness     <= pwdata[30:0];
        sdf_pkg::REG_DAMP:   cfg.damping_coeff <= pwdata;
        sdf_pkg::REG_PLANAR: cfg.planar_mode   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sdf_pkg::REG_REST:   prdata = {1'b0, cfg.rest_length};
      sdf_pkg::REG_STIFF:  prdata = {1'b0, cfg.stiffness};
      sdf_pkg::REG_DAMP:   prdata = cfg.damping_coeff;
      sdf_pkg::REG_PLANAR: prdata = {31'b0, cfg.planar_mode};
      default:             prdata = '0;
    endcase
  end

endmodule

### rtl/core/sdf_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module sdf_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_vld,
  input  logic [sdf_pkg::SUM_W-1:0]    rad,
  input  sdf_pkg::sq_side_t            side_in,
  output logic                         out_vld,
  output logic [sdf_pkg::ROOT_W-1:0]   root,
  output sdf_pkg::sq_side_t            side_out
);

  localparam int N = sdf_pkg::ROOT_W;

  logic                        vld_q  [0:N-1];
  logic [sdf_pkg::SUM_W-1:0]   rad_q  [0:N-1];
  logic [sdf_pkg::REM_W-1:0]   rem_q  [0:N-1];
  logic [sdf_pkg::ROOT_W-1:0]  root_q [0:N-1];
  sdf_pkg::sq_side_t           side_q [0:N-1];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                       vld_p;
    logic [sdf_pkg::SUM_W-1:0]  rad_p;
    logic [sdf_pkg::REM_W-1:0]  rem_p;
    logic [sdf_pkg::ROOT_W-1:0] root_p;
    sdf_pkg::sq_side_t          side_p;
    logic [sdf_pkg::REM_W-1:0]  rem_sh;
    logic [sdf_pkg::REM_W-1:0]  trial;
    logic                       take;

    if (k == 0) begin : g_first
      assign vld_p  = in_vld;
      assign rad_p  = rad;
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_in;
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign rad_p  = rad_q[k-1];
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign side_p = side_q[k-1];
    end

    always_comb begin
      rem_sh = {rem_p[sdf_pkg::REM_W-3:0], rad_p[sdf_pkg::SUM_W-1 -: 2]};
      trial  = {1'b0, root_p, 2'b01};
      take   = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k]  <= rad_p << 2;
        rem_q[k]  <= take ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_p[sdf_pkg::ROOT_W-2:0], take};
        side_q[k] <= side_p;
      end
    end
  end

  assign out_vld  = vld_q[N-1];
  assign root     = root_q[N-1];
  assign side_out = side_q[N-1];

endmodule

### rtl/core/sdf_div.sv
// Pipelined three-lane divider that forms the unit direction vector.
module sdf_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic [2:0][sdf_pkg::DW-1:0]         d,
  input  logic [sdf_pkg::ROOT_W-1:0]          den,
  input  sdf_pkg::dv_side_t                   side_in,
  output logic                                out_vld,
  output logic [2:0][sdf_pkg::U_W-1:0]        u,
  output sdf_pkg::dv_side_t                   side_out
);

  localparam int N = sdf_pkg::QW;

  logic                                 vld_q  [0:N-1];
  logic [2:0][sdf_pkg::NUM_W-1:0]       num_q  [0:N-1];
  logic [2:0][sdf_pkg::QW-1:0]          quo_q  [0:N-1];
  logic [2:0]                           neg_q  [0:N-1];
  logic [sdf_pkg::ROOT_W-1:0]           den_q  [0:N-1];
  sdf_pkg::dv_side_t                    side_q [0:N-1];

  logic [2:0][sdf_pkg::NUM_W-1:0]       num_in;
  logic [2:0]                           neg_in;

  always_comb begin
    logic [sdf_pkg::DW-1:0] mag;
    for (int i = 0; i < 3; i++) begin
      neg_in[i] = d[i][sdf_pkg::DW-1];
      mag       = neg_in[i] ? -d[i] : d[i];
      num_in[i] = {mag, {sdf_pkg::FRAC_BITS{1'b0}}};
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                            vld_p;
    logic [2:0][sdf_pkg::NUM_W-1:0]  num_p;
    logic [2:0][sdf_pkg::QW-1:0]     quo_p;
    logic [2:0]                      neg_p;
    logic [sdf_pkg::ROOT_W-1:0]      den_p;
    sdf_pkg::dv_side_t               side_p;
    logic [sdf_pkg::NUM_W-1:0]       trial;
    logic [2:0]                      take;

    if (k == 0) begin : g_first
      assign vld_p  = in_vld;
      assign num_p  = num_in;
      assign quo_p  = '0;
      assign neg_p  = neg_in;
      assign den_p  = den;
      assign side_p = side_in;
    end else begin : g_next
      assign vld_p  = vld_q[k-1];
      assign num_p  = num_q[k-1];
      assign quo_p  = quo_q[k-1];
      assign neg_p  = neg_q[k-1];
      assign den_p  = den_q[k-1];
      assign side_p = side_q[k-1];
    end

    always_comb begin
      trial = {{(sdf_pkg::NUM_W - sdf_pkg::ROOT_W){1'b0}}, den_p} << (N - 1 - k);
      for (int i = 0; i < 3; i++) begin
        take[i] = (num_p[i] >= trial);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          num_q[k][i] <= take[i] ? num_p[i] - trial : num_p[i];
          quo_q[k][i] <= {quo_p[i][sdf_pkg::QW-2:0], take[i]};
        end
        neg_q[k]  <= neg_p;
        den_q[k]  <= den_p;
        side_q[k] <= side_p;
      end
    end
  end

  always_comb begin
    logic [sdf_pkg::U_W-1:0] qx;
    for (int i = 0; i < 3; i++) begin
      qx   = {1'b0, quo_q[N-1][i]};
      u[i] = neg_q[N-1][i] ? -qx : qx;
    end
  end

  assign out_vld  = vld_q[N-1];
  assign side_out = side_q[N-1];

endmodule

### rtl/core/spring_damper_force_core.sv
// Top level of the pipelined spring-damper force core.
// The core accepts one transaction per clock unless a stall on a valid output holds it, and
// returns the Q16.16 force on the second body through its pipeline (3 input stages, 33 square
// root stages, 1 spring stage, 17 divider stages, 5 output stages); the square root and divider
// pipelines set the latency, while throughput stays at one transaction per cycle. A stall on a
// valid output freezes the whole pipeline. The first body receives the negated force.
// Configuration writes belong in idle periods; pready is always high.
module spring_damper_force_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [31:0] first_pos_x,
  input  logic signed [31:0] first_pos_y,
  input  logic signed [31:0] first_pos_z,
  input  logic signed [31:0] second_pos_x,
  input  logic signed [31:0] second_pos_y,
  input  logic signed [31:0] second_pos_z,
  input  logic signed [31:0] first_vel_x,
  input  logic signed [31:0] first_vel_y,
  input  logic signed [31:0] first_vel_z,
  input  logic signed [31:0] second_vel_x,
  input  logic signed [31:0] second_vel_y,
  input  logic signed [31:0] second_vel_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic signed [31:0] force_z,
  output logic        applied,
  output logic        settled
);

  localparam int F = sdf_pkg::FRAC_BITS;

  sdf_pkg::cfg_t cfg;
  logic          en;

  sdf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready   = 1'b1;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: differences.
  logic [2:0][31:0]           pa, pb, va, vb;
  logic [2:0][sdf_pkg::DW-1:0] d_c, dv_c;
  logic                       s1_vld;
  logic [2:0][sdf_pkg::DW-1:0] s1_d, s1_dv;
  logic [31:0]                s1_v1x, s1_v1y;
  logic                       s1_planar;

  assign pa = {first_pos_z, first_pos_y, first_pos_x};
  assign pb = {second_pos_z, second_pos_y, second_pos_x};
  assign va = {first_vel_z, first_vel_y, first_vel_x};
  assign vb = {second_vel_z, second_vel_y, second_vel_x};

  always_comb begin
    logic zero_lane;
    for (int i = 0; i < 3; i++) begin
      zero_lane = cfg.planar_mode && (i == 2);
      d_c[i]  = zero_lane ? '0 : ({pa[i][31], pa[i]} - {pb[i][31], pb[i]});
      dv_c[i] = zero_lane ? '0 : ({va[i][31], va[i]} - {vb[i][31], vb[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d      <= d_c;
      s1_dv     <= dv_c;
      s1_v1x    <= first_vel_x;
      s1_v1y    <= first_vel_y;
      s1_planar <= cfg.planar_mode;
    end
  end

  // Stage 2: squares, velocity products and the speed check.
  logic                           s2_vld;
  logic [2:0][sdf_pkg::SQ_W-1:0]  s2_sq;
  logic [2:0][sdf_pkg::DVP_W-1:0] s2_dvp;
  logic [2:0][sdf_pkg::DW-1:0]    s2_d;
  logic                           s2_vsmall, s2_planar;
  logic [2:0][sdf_pkg::SQ_W-1:0]  sq_c;
  logic [2:0][sdf_pkg::DVP_W-1:0] dvp_c;
  logic                           vsmall_c;

  always_comb begin
    logic [sdf_pkg::DW-1:0]    mag;
    logic [32:0]               mx, my;
    logic [2*F:0]              vs;
    logic [2*F-1:0]            sqx, sqy;
    for (int i = 0; i < 3; i++) begin
      mag      = s1_d[i][sdf_pkg::DW-1] ? -s1_d[i] : s1_d[i];
      sq_c[i]  = sdf_pkg::SQ_W'(mag) * sdf_pkg::SQ_W'(mag);
      dvp_c[i] = sdf_pkg::DVP_W'($signed(s1_dv[i])) * sdf_pkg::DVP_W'(cfg.damping_coeff);
    end
    mx  = s1_v1x[31] ? -{1'b1, s1_v1x} : {1'b0, s1_v1x};
    my  = s1_v1y[31] ? -{1'b1, s1_v1y} : {1'b0, s1_v1y};
    sqx = (2*F)'(mx[F-1:0]) * (2*F)'(mx[F-1:0]);
    sqy = (2*F)'(my[F-1:0]) * (2*F)'(my[F-1:0]);
    vs  = {1'b0, sqx} + {1'b0, sqy};
    vsmall_c = (mx[32:F] == '0) && (my[32:F] == '0) && !vs[2*F];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_sq     <= sq_c;
      s2_dvp    <= dvp_c;
      s2_d      <= s1_d;
      s2_vsmall <= vsmall_c;
      s2_planar <= s1_planar;
    end
  end

  // Stage 3: squared length and scaled relative velocity.
  logic                         s3_vld;
  logic [sdf_pkg::SUM_W-1:0]    s3_sum;
  sdf_pkg::sq_side_t            s3_side;
  logic [sdf_pkg::SUM_W-1:0]    sum_c;
  sdf_pkg::sq_side_t            side3_c;

  always_comb begin
    logic signed [sdf_pkg::DVP_W-1:0] p;
    logic signed [sdf_pkg::DVP_W-1:0] t;
    sum_c = sdf_pkg::SUM_W'(s2_sq[0]) + sdf_pkg::SUM_W'(s2_sq[1])
          + sdf_pkg::SUM_W'(s2_sq[2]);
    for (int i = 0; i < 3; i++) begin
      p = $signed(s2_dvp[i]);
      t = p + $signed({{(sdf_pkg::DVP_W-F){1'b0}}, {F{p[sdf_pkg::DVP_W-1]}}});
      side3_c.dvc[i] = sdf_pkg::DVC_W'(t >>> F);
    end
    side3_c.d         = s2_d;
    side3_c.fl.zero   = (s2_sq[0] == '0) && (s2_sq[1] == '0) && (s2_sq[2] == '0);
    side3_c.fl.planar = s2_planar;
    side3_c.fl.vsmall = s2_vsmall;
    side3_c.fl.lsmall = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_sum  <= sum_c;
      s3_side <= side3_c;
    end
  end

  logic                        sq_vld;
  logic [sdf_pkg::ROOT_W-1:0]  len;
  sdf_pkg::sq_side_t           sq_side;

  sdf_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s3_vld),
    .rad      (s3_sum),
    .side_in  (s3_side),
    .out_vld  (sq_vld),
    .root     (len),
    .side_out (sq_side)
  );

  // Stage 4: spring product.
  logic                         s4_vld;
  logic [2:0][sdf_pkg::DW-1:0]  s4_d;
  logic [sdf_pkg::ROOT_W-1:0]   s4_len;
  sdf_pkg::dv_side_t            s4_side;
  sdf_pkg::dv_side_t            side4_c;

  always_comb begin
    logic signed [sdf_pkg::DIFF_W-1:0] diff;
    diff = $signed({2'b00, len}) - $signed({4'b0000, cfg.rest_length});
    side4_c.dvc         = sq_side.dvc;
    side4_c.spring_prod = sdf_pkg::SPP_W'(diff)
                        * sdf_pkg::SPP_W'($signed({1'b0, cfg.stiffness}));
    side4_c.fl          = sq_side.fl;
    side4_c.fl.lsmall   = (len[sdf_pkg::ROOT_W-1:F] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_d    <= sq_side.d;
      s4_len  <= len;
      s4_side <= side4_c;
    end
  end

  logic                         dv_vld;
  logic [2:0][sdf_pkg::U_W-1:0] u;
  sdf_pkg::dv_side_t            dv_side;

  sdf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s4_vld),
    .d        (s4_d),
    .den      (s4_len),
    .side_in  (s4_side),
    .out_vld  (dv_vld),
    .u        (u),
    .side_out (dv_side)
  );

  // Stage 5: damping terms and spring force.
  logic                          s5_vld;
  logic [2:0][sdf_pkg::TP_W-1:0] s5_tp;
  logic [sdf_pkg::SPR_W-1:0]     s5_spring;
  logic [2:0][sdf_pkg::U_W-1:0]  s5_u;
  sdf_pkg::flags_t               s5_fl;
  logic [2:0][sdf_pkg::TP_W-1:0] tp_c;
  logic [sdf_pkg::SPR_W-1:0]     spring_c;

  always_comb begin
    logic signed [sdf_pkg::SPP_W-1:0] p;
    logic signed [sdf_pkg::SPP_W-1:0] t;
    for (int i = 0; i < 3; i++) begin
      tp_c[i] = sdf_pkg::TP_W'($signed(dv_side.dvc[i])) * sdf_pkg::TP_W'($signed(u[i]));
    end
    p        = $signed(dv_side.spring_prod);
    t        = p + $signed({{(sdf_pkg::SPP_W-F){1'b0}}, {F{p[sdf_pkg::SPP_W-1]}}});
    spring_c = sdf_pkg::SPR_W'(t >>> F);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else if (en) begin
      s5_vld <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_tp     <= tp_c;
      s5_spring <= spring_c;
      s5_u      <= u;
      s5_fl     <= dv_side.fl;
    end
  end

  // Stage 6: total scalar force along the direction.
  logic                         s6_vld;
  logic [sdf_pkg::TOT_W-1:0]    s6_total;
  logic [2:0][sdf_pkg::U_W-1:0] s6_u;
  sdf_pkg::flags_t              s6_fl;
  logic [sdf_pkg::TOT_W-1:0]    total_c;

  always_comb begin
    logic signed [sdf_pkg::TP_W-1:0]   p;
    logic signed [sdf_pkg::TP_W-1:0]   t;
    logic signed [sdf_pkg::TERM_W-1:0] term;
    logic signed [sdf_pkg::DAMP_W-1:0] damp;
    damp = '0;
    for (int i = 0; i < 3; i++) begin
      p    = $signed(s5_tp[i]);
      t    = p + $signed({{(sdf_pkg::TP_W-F){1'b0}}, {F{p[sdf_pkg::TP_W-1]}}});
      term = sdf_pkg::TERM_W'(t >>> F);
      damp = damp + sdf_pkg::DAMP_W'(term);
    end
    total_c = sdf_pkg::TOT_W'($signed(s5_spring)) - sdf_pkg::TOT_W'(damp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
    end else if (en) begin
      s6_vld <= s5_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_total <= total_c;
      s6_u     <= s5_u;
      s6_fl    <= s5_fl;
    end
  end

  // Stage 7: force components.
  logic                          s7_vld;
  logic [2:0][sdf_pkg::FP_W-1:0] s7_fp;
  sdf_pkg::flags_t               s7_fl;
  logic [2:0][sdf_pkg::FP_W-1:0] fp_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fp_c[i] = sdf_pkg::FP_W'($signed(s6_total)) * sdf_pkg::FP_W'($signed(s6_u[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_vld <= 1'b0;
    end else if (en) begin
      s7_vld <= s6_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_fp <= fp_c;
      s7_fl <= s6_fl;
    end
  end

  // Stage 8: scaling and saturation.
  logic              s8_vld;
  logic [2:0][31:0]  s8_f;
  sdf_pkg::flags_t   s8_fl;
  logic [2:0][31:0]  f_c;

  always_comb begin
    logic signed [sdf_pkg::FP_W-1:0] p;
    logic signed [sdf_pkg::FP_W-1:0] t;
    logic [sdf_pkg::FR_W-1:0]        fr;
    for (int i = 0; i < 3; i++) begin
      p  = $signed(s7_fp[i]);
      t  = p + $signed({{(sdf_pkg::FP_W-F){1'b0}}, {F{p[sdf_pkg::FP_W-1]}}});
      fr = sdf_pkg::FR_W'(t >>> F);
      if ((fr[sdf_pkg::FR_W-1:31] == '0) || (fr[sdf_pkg::FR_W-1:31] == '1)) begin
        f_c[i] = fr[31:0];
      end else begin
        f_c[i] = fr[sdf_pkg::FR_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_vld <= 1'b0;
    end else if (en) begin
      s8_vld <= s7_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_f  <= f_c;
      s8_fl <= s7_fl;
    end
  end

  // Stage 9: settle check and output register.
  logic fsmall_c;

  always_comb begin
    logic [32:0]    mx, my;
    logic [2*F-1:0] sqx, sqy;
    logic [2*F:0]   fs;
    mx  = s8_f[0][31] ? -{1'b1, s8_f[0]} : {1'b0, s8_f[0]};
    my  = s8_f[1][31] ? -{1'b1, s8_f[1]} : {1'b0, s8_f[1]};
    sqx = (2*F)'(mx[F-1:0]) * (2*F)'(mx[F-1:0]);
    sqy = (2*F)'(my[F-1:0]) * (2*F)'(my[F-1:0]);
    fs  = {1'b0, sqx} + {1'b0, sqy};
    fsmall_c = (mx[32:F] == '0) && (my[32:F] == '0) && !fs[2*F];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s8_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_x <= s8_fl.zero ? '0 : s8_f[0];
      force_y <= s8_fl.zero ? '0 : s8_f[1];
      force_z <= s8_fl.zero ? '0 : s8_f[2];
      applied <= !s8_fl.zero;
      settled <= s8_fl.planar && !s8_fl.zero && s8_fl.lsmall && s8_fl.vsmall && fsmall_c;
    end
  end

endmodule

### tb/sv/spring_damper_force_checker.sv
// Checker that predicts and compares every force result of the spring-damper core.
`timescale 1ns / 1ps
module spring_damper_force_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [11:0][31:0]  in_fields,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] force_x,
  input  logic signed [31:0] force_y,
  input  logic signed [31:0] force_z,
  input  logic               applied,
  input  logic               settled,
  input  logic               final_check,
  output int                 pending,
  output int                 fails,
  output int                 settled_seen,
  output int                 zero_seen
);

  localparam logic [127:0] TERM_LIM = (128'd1 << 60) - 1;

  typedef struct packed {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic               app;
    logic               stl;
  } force_t;

  sdf_pkg::cfg_t cfg;
  force_t        force_q[$];

  assign pending = force_q.size();

  function automatic logic [127:0] mag128(input logic signed [63:0] a);
    return {64'b0, a[63] ? 64'(-a) : a};
  endfunction

  function automatic logic signed [63:0] mul_q16(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [127:0] m;
    m = (mag128(a) * mag128(b)) >> sdf_pkg::FRAC_BITS;
    if (m > TERM_LIM) m = TERM_LIM;
    return (a[63] ^ b[63]) ? -$signed(m[63:0]) : $signed(m[63:0]);
  endfunction

  function automatic logic signed [31:0] sat_word(input logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic force_t predict_force(input logic [11:0][31:0] it,
                                           input sdf_pkg::cfg_t c);
    logic signed [63:0] p1 [3];
    logic signed [63:0] p2 [3];
    logic signed [63:0] v1 [3];
    logic signed [63:0] v2 [3];
    logic signed [63:0] d [3];
    logic signed [63:0] u [3];
    logic signed [31:0] f [3];
    logic [127:0]       sumsq;
    logic [127:0]       vs;
    logic [127:0]       fs;
    logic [63:0]        root;
    logic [63:0]        cand;
    logic signed [63:0] len;
    logic signed [63:0] spring;
    logic signed [63:0] damp;
    logic signed [63:0] total;
    force_t             r;
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      p1[i] = (c.planar_mode && i == 2) ? 64'sd0 : 64'($signed(it[i]));
      p2[i] = (c.planar_mode && i == 2) ? 64'sd0 : 64'($signed(it[3 + i]));
      v1[i] = (c.planar_mode && i == 2) ? 64'sd0 : 64'($signed(it[6 + i]));
      v2[i] = (c.planar_mode && i == 2) ? 64'sd0 : 64'($signed(it[9 + i]));
      d[i] = p1[i] - p2[i];
      sumsq += mag128(d[i]) * mag128(d[i]);
    end
    r = '0;
    if (sumsq == 0) return r;
    root = 0;
    for (int b = 33; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'b0, cand} * {64'b0, cand} <= sumsq) root = cand;
    end
    len = $signed(root);
    for (int i = 0; i < 3; i++) u[i] = (d[i] * 64'sd65536) / len;
    spring = mul_q16(len - $signed({33'b0, c.rest_length}), $signed({33'b0, c.stiffness}));
    damp = 0;
    for (int i = 0; i < 3; i++)
      damp += mul_q16(mul_q16(v1[i] - v2[i], 64'(c.damping_coeff)), u[i]);
    total = spring - damp;
    for (int i = 0; i < 3; i++) f[i] = sat_word(mul_q16(total, u[i]));
    r.fx = f[0];
    r.fy = f[1];
    r.fz = f[2];
    r.app = 1'b1;
    if (c.planar_mode) begin
      vs = mag128(v1[0]) * mag128(v1[0]) + mag128(v1[1]) * mag128(v1[1]);
      fs = mag128(64'(f[0])) * mag128(64'(f[0])) + mag128(64'(f[1])) * mag128(64'(f[1]));
      r.stl = (root < 64'd65536) && (vs < (128'd1 << 32)) && (fs < (128'd1 << 32));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    force_t exp_f;
    int     bad;
    bad = 0;
    if (rst) begin
      cfg.rest_length   <= '0;
      cfg.stiffness     <= '0;
      cfg.damping_coeff <= '0;
      cfg.planar_mode   <= 1'b1;
      fails             <= 0;
      settled_seen      <= 0;
      zero_seen         <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (sdf_pkg::reg_idx_t'(paddr[3:2]))
          sdf_pkg::REG_REST:   cfg.rest_length   <= pwdata[30:0];
          sdf_pkg::REG_STIFF:  cfg.stiffness     <= pwdata[30:0];
          sdf_pkg::REG_DAMP:   cfg.damping_coeff <= pwdata;
          sdf_pkg::REG_PLANAR: cfg.planar_mode   <= pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) force_q.push_back(predict_force(in_fields, cfg));
      if (out_valid && !out_stall) begin
        if (force_q.size() == 0) begin
          $display("%0t: unexpected transaction, actual %h %h %h app=%b stl=%b",
                   $time, force_x, force_y, force_z, applied, settled);
          bad = bad + 1;
        end else begin
          exp_f = force_q.pop_front();
          if (exp_f != {force_x, force_y, force_z, applied, settled}) begin
            $display({"%0t: mismatch expected %h %h %h app=%b stl=%b",
                      " actual %h %h %h app=%b stl=%b"},
                     $time, exp_f.fx, exp_f.fy, exp_f.fz, exp_f.app, exp_f.stl,
                     force_x, force_y, force_z, applied, settled);
            bad = bad + 1;
          end
          if (exp_f.stl) settled_seen <= settled_seen + 1;
          if (!exp_f.app) zero_seen <= zero_seen + 1;
        end
      end
      if (final_check && force_q.size() != 0) begin
        $display("%0t: %0d expected transactions never arrived", $time, force_q.size());
        bad = bad + force_q.size();
      end
      fails <= fails + bad;
    end
  end

endmodule

### tb/sv/spring_damper_force_core_tb.sv
// Stimulus and verdict for the spring-damper force core testbench.
`timescale 1ns / 1ps
module spring_damper_force_core_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 158;

  logic              clk;
  logic              rst;
  logic              psel, penable, pwrite;
  logic [3:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid, in_stall;
  logic [11:0][31:0] stim;
  logic              out_valid, out_stall;
  logic signed [31:0] force_x, force_y, force_z;
  logic              applied, settled;
  logic              final_check;
  logic              hold_go;
  int                pending, fails, settled_seen, zero_seen;
  int                idle_pct, stall_pct, hold_left, cycles, sent;

  spring_damper_force_core DUT (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .first_pos_x(stim[0]), .first_pos_y(stim[1]), .first_pos_z(stim[2]),
    .second_pos_x(stim[3]), .second_pos_y(stim[4]), .second_pos_z(stim[5]),
    .first_vel_x(stim[6]), .first_vel_y(stim[7]), .first_vel_z(stim[8]),
    .second_vel_x(stim[9]), .second_vel_y(stim[10]), .second_vel_z(stim[11]),
    .out_valid(out_valid), .out_stall(out_stall),
    .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .applied(applied), .settled(settled)
  );

  spring_damper_force_checker force_chk (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_fields(stim),
    .out_valid(out_valid), .out_stall(out_stall),
    .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .applied(applied), .settled(settled), .final_check(final_check),
    .pending(pending), .fails(fails), .settled_seen(settled_seen), .zero_seen(zero_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic reg_write(input sdf_pkg::reg_idx_t idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic load_config(input logic [30:0] rest, input logic [30:0] stiff,
                             input logic [31:0] damp, input logic planar);
    while (pending != 0) @(negedge clk);
    repeat (70) @(negedge clk);
    reg_write(sdf_pkg::REG_REST, {1'b0, rest});
    reg_write(sdf_pkg::REG_STIFF, {1'b0, stiff});
    reg_write(sdf_pkg::REG_DAMP, damp);
    reg_write(sdf_pkg::REG_PLANAR, {31'b0, planar});
  endtask

  task automatic send_item(input logic [11:0][31:0] it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    stim = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  function automatic logic [31:0] near_zero(input int span);
    return 32'($urandom_range(2 * span) - span);
  endfunction

  function automatic logic [11:0][31:0] random_pair();
    logic [11:0][31:0] it;
    int                kind;
    kind = $urandom_range(3);
    for (int i = 0; i < 12; i++) begin
      case (kind)
        0: it[i] = $urandom;
        1: it[i] = near_zero(1 << 20);
        2: it[i] = near_zero(1 << 15);
        default: it[i] = (i >= 3 && i < 6) ? it[i - 3] + near_zero(1 << 18) : $urandom;
      endcase
    end
    return it;
  endfunction

  task automatic send_directed();
    logic [11:0][31:0] it;
    it = '0;
    send_item(it);
    for (int i = 6; i < 12; i++) it[i] = $urandom;
    send_item(it);
    it = '0;
    it[2] = 32'h7FFFFFFF;
    it[5] = 32'h80000000;
    send_item(it);
    for (int ax = 0; ax < 3; ax++) begin
      it = '0;
      it[ax] = 32'h7FFFFFFF;
      it[3 + ax] = 32'h80000000;
      send_item(it);
      it[ax] = 32'h80000000;
      it[3 + ax] = 32'h7FFFFFFF;
      send_item(it);
    end
    for (int i = 0; i < 12; i++) it[i] = (i % 2) ? 32'h80000000 : 32'h7FFFFFFF;
    send_item(it);
    for (int i = 0; i < 12; i++) it[i] = 32'h7FFFFFFF;
    send_item(it);
    for (int i = 0; i < 12; i++) it[i] = 32'hFFFFFFFF;
    it[3] = 32'h0;
    send_item(it);
    it = '0;
    it[0] = 32'h00008000;
    it[6] = 32'h00001000;
    send_item(it);
    it = '0;
    it[0] = 32'h00000001;
    send_item(it);
    it = '0;
    it[0] = 32'h00010000;
    it[6] = 32'h00010000;
    send_item(it);
    it = '0;
    it[1] = 32'h00003000;
    it[4] = 32'hFFFFD000;
    it[9] = 32'h00020000;
    it[11] = 32'h7FFFFFFF;
    send_item(it);
    repeat (4) send_item(random_pair());
  endtask

  task automatic run_phase(input int idle, input int stall, input bit pressure);
    idle_pct = idle;
    stall_pct = stall;
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      if (pressure && n == 40) hold_go = 1'b1;
      send_item(random_pair());
    end
    in_valid = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    stim = '0;
    final_check = 1'b0;
    hold_go = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    sent = 0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    load_config(31'd0, 31'h10000, 32'd0, 1'b1);
    send_directed();
    in_valid = 1'b0;
    run_phase(0, 0, 1'b1);
    load_config(31'h7FFFFFFF, 31'h7FFFFFFF, 32'h80000000, 1'b0);
    run_phase(60, 0, 1'b0);
    load_config(31'($urandom_range(32'h300000)), 31'($urandom_range(32'h40000)),
                near_zero(32'h40000), 1'b1);
    run_phase(0, 60, 1'b0);
    load_config(31'($urandom_range(32'h300000)), 31'($urandom_range(32'h40000)),
                32'h7FFFFFFF, 1'b0);
    run_phase(26, 26, 1'b0);

    while (pending != 0) @(negedge clk);
    repeat (70) @(negedge clk);
    final_check = 1'b1;
    @(negedge clk);
    final_check = 1'b0;
    @(negedge clk);
    $display("Sent %0d transactions over four register settings and idle mixes,", sent);
    $display("with %0d zero-distance and %0d settled results among them.",
             zero_seen, settled_seen);
    if (fails == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/sdf_pkg.sv
rtl/core/sdf_regs.sv
rtl/core/sdf_sqrt.sv
rtl/core/sdf_div.sv
rtl/core/spring_damper_force_core.sv
tb/sv/spring_damper_force_checker.sv
tb/sv/spring_damper_force_core_tb.sv
